// ----- design/pidcs_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pidcs_pkg
// Shared types and constants for the PID controller with clamp and slew limit.
// ---------------------------------------------------------------------------
package pidcs_pkg;

    // Default sizes handed to the top level parameters
    localparam int DATA_WIDTH_DEF     = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int ACC_WIDTH_DEF      = 32;

    // Fixed register widths
    localparam int GAIN_W    = 16;
    localparam int BOUND_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_TRACK = 2'd0,   // setpoint and measured value
        OP_ERROR = 2'd1,   // error given directly
        OP_CLEAR = 2'd2,   // clear error history and integral
        OP_RSVD  = 2'd3    // ignored
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_OUT_UPPER  = 3'd3,
        REG_OUT_LOWER  = 3'd4,
        REG_STEP_LIMIT = 3'd5,
        REG_CLAMP_EN   = 3'd6,
        REG_SLEW_EN    = 3'd7
    } cfg_idx_t;

    // Register file contents as seen by the datapath
    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [BOUND_W-1:0] out_upper;
        logic [BOUND_W-1:0] out_lower;
        logic [BOUND_W-1:0] step_limit;
        logic               clamp_enable;
        logic               slew_enable;
    } cfg_t;

endpackage

// ----- design/pidcs_cfg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pidcs_cfg
// Configuration register file: gains, clamp bounds, step limit and enables.
// ---------------------------------------------------------------------------
module pidcs_cfg import pidcs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always accepted and land in the register file in the cycle after
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                REG_PROP_GAIN:  cfg_next.prop_gain    = cfg_data;
                REG_INTEG_GAIN: cfg_next.integ_gain   = cfg_data;
                REG_DERIV_GAIN: cfg_next.deriv_gain   = cfg_data;
                REG_OUT_UPPER:  cfg_next.out_upper    = cfg_data;
                REG_OUT_LOWER:  cfg_next.out_lower    = cfg_data;
                REG_STEP_LIMIT: cfg_next.step_limit   = cfg_data;
                REG_CLAMP_EN:   cfg_next.clamp_enable = cfg_data[0];
                REG_SLEW_EN:    cfg_next.slew_enable  = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain    <= 16'sd256;
            cfg_reg.integ_gain   <= '0;
            cfg_reg.deriv_gain   <= '0;
            cfg_reg.out_upper    <= 16'h7FFF;
            cfg_reg.out_lower    <= 16'h8000;
            cfg_reg.step_limit   <= 16'hFFFF;
            cfg_reg.clamp_enable <= 1'b1;
            cfg_reg.slew_enable  <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- design/pidcs_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pidcs_core
// Single-pass PID datapath: error, saturating integral, three gain products,
// floor shift, clamp or saturate, slew limit. Holds the controller state.
// ---------------------------------------------------------------------------
module pidcs_core import pidcs_pkg::*; #(
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int ACC_WIDTH      = ACC_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  op_t                   opcode,
    input  logic [DATA_WIDTH-1:0] setpoint,
    input  logic [DATA_WIDTH-1:0] measured,
    input  logic [DATA_WIDTH-1:0] direct_error,
    input  cfg_t                  cfg,
    output logic [DATA_WIDTH-1:0] drive,
    output logic                  clamped,
    output logic                  slew_limited
);

    localparam int DW     = DATA_WIDTH;
    localparam int AW     = ACC_WIDTH;
    localparam int IW     = ((AW > DW) ? AW : DW) + 1;
    localparam int PW_E   = GAIN_W + DW;
    localparam int PW_I   = GAIN_W + AW;
    localparam int PW_D   = GAIN_W + DW + 1;
    localparam int SUM_W  = ((PW_I > PW_D) ? PW_I : PW_D) + 2;
    localparam int DIFF_W = SUM_W + 1;

    localparam logic signed [IW-1:0] I_MAX = {{(IW-AW+1){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [IW-1:0] I_MIN = ~I_MAX;
    localparam logic signed [SUM_W-1:0] D_MAX = {{(SUM_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] D_MIN = ~D_MAX;
    localparam logic signed [DW-1:0] E_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] E_MIN = ~E_MAX;

    // Controller state
    logic signed [DW-1:0] prev_error_reg;
    logic signed [AW-1:0] integ_sum_reg;
    logic signed [DW-1:0] prev_drive_reg;
    logic signed [DW-1:0] prev_error_next;
    logic signed [AW-1:0] integ_sum_next;
    logic signed [DW-1:0] prev_drive_next;

    logic signed [DW:0]       track_diff;
    logic signed [DW-1:0]     err;
    logic signed [IW-1:0]     integ_wide;
    logic signed [AW-1:0]     integ_new;
    logic signed [DW:0]       deriv;
    logic signed [GAIN_W-1:0] gp, gi, gd;
    logic signed [PW_E-1:0]   prod_p;
    logic signed [PW_I-1:0]   prod_i;
    logic signed [PW_D-1:0]   prod_d;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  pre;
    logic signed [SUM_W-1:0]  upper_ext, lower_ext;
    logic signed [SUM_W-1:0]  y_bound;
    logic signed [DIFF_W-1:0] y_ext, prev_ext, diff, step_ext, step_neg, y_slew;
    logic                     limited;
    logic [DW-1:0]            drive_new;

    // Error select and saturation of the tracking difference
    always_comb begin
        track_diff = {setpoint[DW-1], setpoint} - {measured[DW-1], measured};
        if (opcode == OP_TRACK) begin
            if (track_diff[DW] != track_diff[DW-1]) begin
                err = track_diff[DW] ? E_MIN : E_MAX;
            end else begin
                err = track_diff[DW-1:0];
            end
        end else begin
            err = direct_error;
        end
    end

    // Saturating integral
    always_comb begin
        integ_wide = {{(IW-AW){integ_sum_reg[AW-1]}}, integ_sum_reg}
                   + {{(IW-DW){err[DW-1]}}, err};
        if (integ_wide > I_MAX) begin
            integ_new = I_MAX[AW-1:0];
        end else if (integ_wide < I_MIN) begin
            integ_new = I_MIN[AW-1:0];
        end else begin
            integ_new = integ_wide[AW-1:0];
        end
    end

    // Gain products and their sum
    assign deriv  = {err[DW-1], err} - {prev_error_reg[DW-1], prev_error_reg};
    assign gp     = cfg.prop_gain;
    assign gi     = cfg.integ_gain;
    assign gd     = cfg.deriv_gain;
    assign prod_p = gp * err;
    assign prod_i = gi * integ_new;
    assign prod_d = gd * deriv;
    assign sum    = {{(SUM_W-PW_E){prod_p[PW_E-1]}}, prod_p}
                  + {{(SUM_W-PW_I){prod_i[PW_I-1]}}, prod_i}
                  + {{(SUM_W-PW_D){prod_d[PW_D-1]}}, prod_d};
    assign pre    = sum >>> GAIN_FRAC_BITS;

    // Clamp to bounds (upper first) or saturate to the output width
    assign upper_ext = {{(SUM_W-BOUND_W){cfg.out_upper[BOUND_W-1]}}, cfg.out_upper};
    assign lower_ext = {{(SUM_W-BOUND_W){cfg.out_lower[BOUND_W-1]}}, cfg.out_lower};

    always_comb begin
        if (cfg.clamp_enable) begin
            if (pre > upper_ext) begin
                y_bound = upper_ext;
            end else if (pre < lower_ext) begin
                y_bound = lower_ext;
            end else begin
                y_bound = pre;
            end
        end else begin
            if (pre > D_MAX) begin
                y_bound = D_MAX;
            end else if (pre < D_MIN) begin
                y_bound = D_MIN;
            end else begin
                y_bound = pre;
            end
        end
    end

    // Slew limit against the previous output
    always_comb begin
        y_ext    = {y_bound[SUM_W-1], y_bound};
        prev_ext = {{(DIFF_W-DW){prev_drive_reg[DW-1]}}, prev_drive_reg};
        step_ext = {{(DIFF_W-BOUND_W){1'b0}}, cfg.step_limit};
        step_neg = -step_ext;
        diff     = y_ext - prev_ext;
        y_slew   = y_ext;
        limited  = 1'b0;
        if (cfg.slew_enable) begin
            if (diff > step_ext) begin
                y_slew  = prev_ext + step_ext;
                limited = 1'b1;
            end else if (diff < step_neg) begin
                y_slew  = prev_ext - step_ext;
                limited = 1'b1;
            end
        end
    end

    assign drive_new = y_slew[DW-1:0];

    // Result select: clear and unused codes return the held output
    always_comb begin
        case (opcode)
            OP_TRACK, OP_ERROR: begin
                drive        = drive_new;
                clamped      = (y_bound != pre);
                slew_limited = limited;
            end
            default: begin
                drive        = prev_drive_reg;
                clamped      = 1'b0;
                slew_limited = 1'b0;
            end
        endcase
    end

    // State update for the item in flight
    always_comb begin
        prev_error_next = prev_error_reg;
        integ_sum_next  = integ_sum_reg;
        prev_drive_next = prev_drive_reg;
        if (fire) begin
            case (opcode)
                OP_TRACK, OP_ERROR: begin
                    prev_error_next = err;
                    integ_sum_next  = integ_new;
                    prev_drive_next = drive_new;
                end
                OP_CLEAR: begin
                    prev_error_next = '0;
                    integ_sum_next  = '0;
                end
                default: begin
                    prev_error_next = prev_error_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_error_reg <= '0;
            integ_sum_reg  <= '0;
            prev_drive_reg <= '0;
        end else begin
            prev_error_reg <= prev_error_next;
            integ_sum_reg  <= integ_sum_next;
            prev_drive_reg <= prev_drive_next;
        end
    end

endmodule

// ----- design/pid_with_clamp_and_slew_limit.sv -----
`timescale 1ns / 1ps
// Path: input register, then result register; an item moves from one to the other
// when the result register is free, so a sink holding off stalls it in the input stage.
// Throughput: one item per cycle while the sink takes results; the whole step, including the three gain multipliers,
// is one combinational pass between the input register and the result register.
// Reset (aresetn low, synchronous): both stages empty, error history, integral and
// previous output cleared, configuration registers return to their defaults.
// ---------------------------------------------------------------------------
// pid_with_clamp_and_slew_limit
// Positional PID controller with output clamp and slew limit, stream ports.
// ---------------------------------------------------------------------------
module pid_with_clamp_and_slew_limit import pidcs_pkg::*; #(
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int ACC_WIDTH      = ACC_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [CFG_DAT_W-1:0]                  cfg_data,
    // input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // setpoint, measured, direct_error (lowest bits first)
    input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
    // opcode
    input  logic [1:0]                            s_tuser,
    // result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // drive
    output logic [((DATA_WIDTH+7)/8)*8-1:0]       m_tdata,
    // clamped, slew_limited (lowest bit first)
    output logic [1:0]                            m_tuser
);

    localparam int DW        = DATA_WIDTH;
    localparam int M_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    cfg_t cfg;

    // Input stage
    logic          in_vld_reg, in_vld_next;
    op_t           op_reg;
    logic [DW-1:0] sp_reg, ms_reg, de_reg;

    // Result stage
    logic          m_vld_reg, m_vld_next;
    logic [DW-1:0] drive_reg;
    logic          clamped_reg, limited_reg;

    logic          out_free, fire, s_accept;
    logic [DW-1:0] drive_c;
    logic          clamped_c, limited_c;

    pidcs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidcs_core #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .ACC_WIDTH      (ACC_WIDTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .opcode       (op_reg),
        .setpoint     (sp_reg),
        .measured     (ms_reg),
        .direct_error (de_reg),
        .cfg          (cfg),
        .drive        (drive_c),
        .clamped      (clamped_c),
        .slew_limited (limited_c)
    );

    // Handshake: an item moves on whenever the result register is free
    assign out_free = !m_vld_reg || m_tready;
    assign fire     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_accept) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
        m_vld_next = m_vld_reg;
        if (fire) begin
            m_vld_next = 1'b1;
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end
    end

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
            m_vld_reg  <= m_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg <= op_t'(s_tuser);
            sp_reg <= s_tdata[DW-1:0];
            ms_reg <= s_tdata[2*DW-1:DW];
            de_reg <= s_tdata[3*DW-1:2*DW];
        end
        if (fire) begin
            drive_reg   <= drive_c;
            clamped_reg <= clamped_c;
            limited_reg <= limited_c;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = M_TDATA_W'(drive_reg);
    assign m_tuser  = {limited_reg, clamped_reg};

    // Input side stalls only when both stages are full and the sink holds off
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_vld_reg && m_vld_reg && !m_tready))
        else $error("input stalled with a free stage");

    // A new result appears only after an item sat in the input stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_vld_reg))
        else $error("result without an input item");

    // Clear items report no flags
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && op_reg == OP_CLEAR) |=> (m_tuser == 2'b00))
        else $error("clear item flagged");

    // No slew flag with the step limit off
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !cfg.slew_enable) |=> !m_tuser[1])
        else $error("slew flag while slew limiting is off");

endmodule
